// File: rtl/ldc_pkg.sv
// Shared types, constants, the default year table and month functions of the lunar date converter.
package ldc_pkg;

  localparam int NUM_YEARS = 7;
  localparam int FLAGS_W = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int TABLE_YEARS_DEF = 7;
  localparam int BASE_YEAR_DEF = 2025;

  localparam logic [CFG_IDX_W-1:0] REG_FLAGS = 3'd7;

  localparam logic [31:0] DAY_SECS = 32'd86400;
  // day count is resolved to this many bits; anything longer is past every year
  localparam int DIV_BITS = 9;
  localparam logic [31:0] DIV_LIMIT = 32'(86400 * (2 ** DIV_BITS));

  // 86400 = 675 << 7; days = ((secs >> 7) * ceil(2^29 / 675)) >> 29, exact below DIV_LIMIT
  localparam int DAY_SHIFT = 7;
  localparam logic [19:0] DAY_RECIP = 20'd795365;
  localparam int RECIP_SHIFT = 29;

  localparam logic [FLAGS_W-1:0] FLAGS_RESET = 14'd82;

  typedef logic [NUM_YEARS-1:0][31:0] start_arr_t;

  localparam start_arr_t START_RESET = {
    32'd1931986800, 32'd1901401200, 32'd1868223600, 32'd1837638000,
    32'd1807052400, 32'd1773874800, 32'd1743202800
  };

  localparam logic [2:0] HOL_NONE = 3'd0;
  localparam logic [2:0] HOL_MAGHA = 3'd1;
  localparam logic [2:0] HOL_VISAKHA = 3'd2;
  localparam logic [2:0] HOL_ASALHA = 3'd3;
  localparam logic [2:0] HOL_OK_PHANSA = 3'd4;
  localparam logic [2:0] HOL_KHAO_PHANSA = 3'd5;
  localparam logic [2:0] HOL_ATTAMI = 3'd6;

  typedef struct packed {
    logic load;
    logic search;
    logic div_step;
    logic walk_step;
    logic emit;
    logic ok;
  } ldc_cmd_t;

  typedef struct packed {
    logic search_hit;
    logic walk_end;
    logic walk_ok;
  } ldc_sts_t;

  // length of the month in walk position slot
  function automatic logic [4:0] month_len(input logic [3:0] slot, input logic lm,
                                           input logic ld);
    logic [3:0] s;
    logic [4:0] len;
    s = slot;
    len = 5'd29;
    if (lm && slot > 4'd4) s = slot - 4'd1;
    if (lm && slot == 4'd4) len = 5'd30;
    else if (s == 4'd2 && ld) len = 5'd30;
    else if (s[0]) len = 5'd30;
    return len;
  endfunction

  // {repeated month 8 mark, month number} of walk position slot
  function automatic logic [4:0] slot_month(input logic [3:0] slot, input logic lm);
    logic [4:0] r;
    if (lm) begin
      if (slot <= 4'd3) r = {1'b0, slot + 4'd5};
      else if (slot == 4'd4) r = {1'b1, 4'd8};
      else if (slot <= 4'd8) r = {1'b0, slot + 4'd4};
      else r = {1'b0, slot - 4'd8};
    end else begin
      if (slot <= 4'd7) r = {1'b0, slot + 4'd5};
      else r = {1'b0, slot - 4'd7};
    end
    return r;
  endfunction

endpackage

// File: rtl/ldc_cfg.sv
// Configuration registers: per-year month-5 start times and leap flags.
module ldc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [ldc_pkg::CFG_IDX_W-1:0]    index,
  input  logic [ldc_pkg::CFG_DATA_W-1:0]   data,
  output ldc_pkg::start_arr_t              year_start,
  output logic [ldc_pkg::FLAGS_W-1:0]      year_flags
);
  import ldc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_start <= START_RESET;
      year_flags <= FLAGS_RESET;
    end else if (we) begin
      if (index == REG_FLAGS) begin
        year_flags <= data[FLAGS_W-1:0];
      end else begin
        year_start[index] <= data;
      end
    end
  end

endmodule

// File: rtl/ldc_ctrl.sv
// Sequencer: year search, day-count division, month walk, result write.
module ldc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ldc_pkg::ldc_sts_t sts,
  output ldc_pkg::ldc_cmd_t cmd,
  output logic              busy
);
  import ldc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_WALK   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.search_hit) begin
          state_next = ST_DIV;
        end else begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_end) begin
          cmd.emit = 1'b1;
          cmd.ok = sts.walk_ok;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: rtl/ldc_dp.sv
// Datapath: start search, reciprocal day count, month walk and result decode.
module ldc_dp #(
  parameter int TABLE_YEARS = ldc_pkg::TABLE_YEARS_DEF,
  parameter int BASE_YEAR = ldc_pkg::BASE_YEAR_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [31:0]                 epoch_seconds,
  input  ldc_pkg::start_arr_t         year_start,
  input  logic [ldc_pkg::FLAGS_W-1:0] year_flags,
  input  ldc_pkg::ldc_cmd_t           cmd,
  output ldc_pkg::ldc_sts_t           sts,
  output logic                        done,
  output logic                        valid_res,
  output logic [11:0]                 year_ce,
  output logic [3:0]                  lunar_month,
  output logic                        second_eighth,
  output logic                        has_leap_month,
  output logic                        waxing,
  output logic [3:0]                  lunar_day,
  output logic [3:0]                  zodiac_index,
  output logic                        holy_day,
  output logic [2:0]                  holiday_code
);
  import ldc_pkg::*;

  localparam int ZBASE = ((BASE_YEAR % 4096) + 12000 - 2020) % 12;

  logic [31:0] t_q;
  logic [2:0]  idx;
  logic        lm;
  logic        ld;
  logic [31:0] rem;
  logic [8:0]  days;
  logic [3:0]  slot;
  logic        far;

  // start search: a borrow-free difference means that start is not after t
  logic [NUM_YEARS-1:0][32:0] diffs;
  logic        hit;
  logic [2:0]  hit_idx;
  logic [31:0] hit_diff;
  logic [6:0]  lm_bits;
  logic [6:0]  ld_bits;

  assign lm_bits = year_flags[6:0];
  assign ld_bits = year_flags[13:7];

  always_comb begin
    for (int i = 0; i < NUM_YEARS; i++) begin
      diffs[i] = {1'b0, t_q} - {1'b0, year_start[i]};
    end
  end

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    hit_diff = '0;
    for (int i = 0; i < TABLE_YEARS; i++) begin
      if (!diffs[i][32]) begin
        hit = 1'b1;
        hit_idx = 3'(i);
        hit_diff = diffs[i][31:0];
      end
    end
  end

  // whole days by reciprocal multiply; only valid while rem is below DIV_LIMIT
  logic [37:0] q_prod;
  assign q_prod = {19'b0, rem[DAY_SHIFT +: 19]} * {18'b0, DAY_RECIP};

  // month walk
  logic [4:0] len;
  logic       w_hit;
  logic       w_last;
  assign len = month_len(slot, lm, ld);
  assign w_hit = (days < {4'b0, len});
  assign w_last = (slot == (lm ? 4'd12 : 4'd11));

  always_comb begin
    sts.search_hit = hit && (t_q != '0);
    sts.walk_end = far || w_hit || w_last;
    sts.walk_ok = !far && w_hit;
  end

  // result decode from the final slot and day offset
  logic [4:0]  ms;
  logic [3:0]  r_month;
  logic        r_second;
  logic        r_wax;
  logic [3:0]  r_day;
  logic        r_holy;
  logic [2:0]  r_hol;
  logic [4:0]  zsum;
  logic [3:0]  r_zod;
  logic [11:0] r_year;

  always_comb begin
    ms = slot_month(slot, lm);
    r_second = ms[4];
    r_month = ms[3:0];
    r_wax = (days < 9'd15);
    r_day = r_wax ? (days[3:0] + 4'd1) : 4'(days[4:0] - 5'd14);
    r_holy = (r_day == 4'd8) || (r_wax && r_day == 4'd15)
          || (!r_wax && r_month[0] && r_day == 4'd14)
          || (!r_wax && !r_month[0] && r_day == 4'd15);
    r_hol = HOL_NONE;
    if (r_wax && r_day == 4'd15) begin
      priority if (r_month == 4'd11) r_hol = HOL_OK_PHANSA;
      else if (lm) begin
        if (r_month == 4'd4) r_hol = HOL_MAGHA;
        else if (r_month == 4'd7) r_hol = HOL_VISAKHA;
        else if (r_month == 4'd8 && r_second) r_hol = HOL_ASALHA;
      end else begin
        if (r_month == 4'd3) r_hol = HOL_MAGHA;
        else if (r_month == 4'd6) r_hol = HOL_VISAKHA;
        else if (r_month == 4'd8) r_hol = HOL_ASALHA;
      end
    end else if (!r_wax && r_day == 4'd1) begin
      if (r_month == 4'd8 && (!lm || r_second)) r_hol = HOL_KHAO_PHANSA;
    end else if (!r_wax && r_day == 4'd8) begin
      if (r_month == (lm ? 4'd7 : 4'd6)) r_hol = HOL_ATTAMI;
    end
    r_year = 12'(BASE_YEAR) + {9'b0, idx};
    zsum = 5'(ZBASE) + {2'b0, idx};
    r_zod = (zsum >= 5'd12) ? 4'(zsum - 5'd12) : zsum[3:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) t_q <= epoch_seconds;
    if (cmd.search) begin
      idx <= hit_idx;
      lm <= lm_bits[hit_idx];
      ld <= ld_bits[hit_idx];
      rem <= hit_diff;
      slot <= '0;
    end
    if (cmd.div_step) begin
      far <= (rem >= DIV_LIMIT);
      days <= q_prod[RECIP_SHIFT +: DIV_BITS];
    end
    if (cmd.walk_step && !w_hit) begin
      days <= days - {4'b0, len};
      slot <= slot + 4'd1;
    end
    if (cmd.emit) begin
      valid_res <= cmd.ok;
      year_ce <= cmd.ok ? r_year : '0;
      lunar_month <= cmd.ok ? r_month : '0;
      second_eighth <= cmd.ok && r_second;
      has_leap_month <= cmd.ok && lm;
      waxing <= cmd.ok && r_wax;
      lunar_day <= cmd.ok ? r_day : '0;
      zodiac_index <= cmd.ok ? r_zod : '0;
      holy_day <= cmd.ok && r_holy;
      holiday_code <= cmd.ok ? r_hol : HOL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule

// File: rtl/lunar_date_converter.sv
// Top level of the Unix time to Thai lunar date converter.
//
//   channel  | signals                                   | transaction
//   ---------+-------------------------------------------+------------------------
//   request  | start, busy, epoch_seconds                | start high, busy low
//   result   | done, valid_res .. holiday_code           | done high, one cycle
//   config   | cfg_we, cfg_index, cfg_data               | cfg_we high
//
// A request that misses every year ends after the search step; else it runs a search step,
// a reciprocal-multiply day count step and a month walk through the months in order,
// using the single shared month-length compare/subtract.
// The result is registered in the last step and shows in the cycle after it; busy falls in that same cycle.
// Reset is synchronous and restores the default year table.
// The result strobe cannot be held off; requests wait on busy only.
module lunar_date_converter #(
  parameter int TABLE_YEARS = ldc_pkg::TABLE_YEARS_DEF,
  parameter int BASE_YEAR = ldc_pkg::BASE_YEAR_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [31:0]                    epoch_seconds,
  input  logic                           cfg_we,
  input  logic [ldc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           done,
  output logic                           valid_res,
  output logic [11:0]                    year_ce,
  output logic [3:0]                     lunar_month,
  output logic                           second_eighth,
  output logic                           has_leap_month,
  output logic                           waxing,
  output logic [3:0]                     lunar_day,
  output logic [3:0]                     zodiac_index,
  output logic                           holy_day,
  output logic [2:0]                     holiday_code
);
  import ldc_pkg::*;

  start_arr_t           year_start;
  logic [FLAGS_W-1:0]   year_flags;
  ldc_cmd_t             cmd;
  ldc_sts_t             sts;

  ldc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .we         (cfg_we),
    .index      (cfg_index),
    .data       (cfg_data),
    .year_start (year_start),
    .year_flags (year_flags)
  );

  ldc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ldc_dp #(
    .TABLE_YEARS (TABLE_YEARS),
    .BASE_YEAR   (BASE_YEAR)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .epoch_seconds  (epoch_seconds),
    .year_start     (year_start),
    .year_flags     (year_flags),
    .cmd            (cmd),
    .sts            (sts),
    .done           (done),
    .valid_res      (valid_res),
    .year_ce        (year_ce),
    .lunar_month    (lunar_month),
    .second_eighth  (second_eighth),
    .has_leap_month (has_leap_month),
    .waxing         (waxing),
    .lunar_day      (lunar_day),
    .zodiac_index   (zodiac_index),
    .holy_day       (holy_day),
    .holiday_code   (holiday_code)
  );

endmodule

// File: sim/ldc_checker.sv
// Scoreboard for the lunar date converter: shadows the year table, predicts and compares.
`timescale 1ns / 100ps

module ldc_checker #(
  parameter int TABLE_YEARS = ldc_pkg::TABLE_YEARS_DEF,
  parameter int BASE_YEAR = ldc_pkg::BASE_YEAR_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [31:0]                    epoch_seconds,
  input  logic                           cfg_we,
  input  logic [ldc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           done,
  input  logic                           valid_res,
  input  logic [11:0]                    year_ce,
  input  logic [3:0]                     lunar_month,
  input  logic                           second_eighth,
  input  logic                           has_leap_month,
  input  logic                           waxing,
  input  logic [3:0]                     lunar_day,
  input  logic [3:0]                     zodiac_index,
  input  logic                           holy_day,
  input  logic [2:0]                     holiday_code,
  output int                             n_fail,
  output int                             n_pending,
  output int                             n_checked,
  output int                             n_dated,
  output int                             n_holidays
);
  import ldc_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [11:0] year;
    logic [3:0]  month;
    logic        repeat8;
    logic        leap;
    logic        wax;
    logic [3:0]  day;
    logic [3:0]  zodiac;
    logic        holy;
    logic [2:0]  holiday;
  } lunar_date_t;

  logic [31:0]        year_start_q [NUM_YEARS];
  logic [FLAGS_W-1:0] flags_q;
  lunar_date_t        expected_dates [$];

  function automatic lunar_date_t convert_time(input logic [31:0] t);
    lunar_date_t d;
    int found;
    int k;
    int pos;
    int unsigned days;
    logic lm;
    logic ld;
    logic [3:0] mon;
    logic [4:0] len;
    logic [3:0] mon_seq [$];
    logic [4:0] len_seq [$];
    logic rep_seq [$];
    int unsigned yr;
    d = '0;
    if (t == 32'd0) return d;
    found = -1;
    for (k = 0; k < TABLE_YEARS; k++)
      if (year_start_q[k] <= t) found = k;
    if (found < 0) return d;
    lm = flags_q[found];
    ld = flags_q[NUM_YEARS + found];
    days = (t - year_start_q[found]) / DAY_SECS;
    // month order 5..12,1..4 with alternating 29/30 days; leap month is a second 8
    for (k = 0; k < 12; k++) begin
      mon = 4'((k + 4) % 12 + 1);
      len = k[0] ? 5'd30 : 5'd29;
      if (mon == 4'd7 && ld) len = 5'd30;
      mon_seq.push_back(mon);
      len_seq.push_back(len);
      rep_seq.push_back(1'b0);
      if (k == 3 && lm) begin
        mon_seq.push_back(4'd8);
        len_seq.push_back(5'd30);
        rep_seq.push_back(1'b1);
      end
    end
    pos = -1;
    for (k = 0; k < mon_seq.size(); k++) begin
      if (pos < 0) begin
        if (days < len_seq[k]) pos = k;
        else days -= len_seq[k];
      end
    end
    if (pos < 0) return d;
    yr = (BASE_YEAR + found) & 32'hFFF;
    d.ok = 1'b1;
    d.year = yr[11:0];
    d.month = mon_seq[pos];
    d.repeat8 = rep_seq[pos];
    d.leap = lm;
    d.wax = days < 15;
    d.day = d.wax ? 4'(days + 1) : 4'(days - 14);
    d.zodiac = 4'((yr + 12000 - 2020) % 12);
    d.holy = (d.day == 4'd8) || (d.wax && d.day == 4'd15) ||
             (!d.wax && d.month[0] && d.day == 4'd14) ||
             (!d.wax && !d.month[0] && d.day == 4'd15);
    d.holiday = HOL_NONE;
    if (d.wax && d.day == 4'd15) begin
      if (d.month == 4'd11) d.holiday = HOL_OK_PHANSA;
      else if (d.month == (lm ? 4'd4 : 4'd3)) d.holiday = HOL_MAGHA;
      else if (d.month == (lm ? 4'd7 : 4'd6)) d.holiday = HOL_VISAKHA;
      else if (d.month == 4'd8 && (!lm || d.repeat8)) d.holiday = HOL_ASALHA;
    end else if (!d.wax && d.day == 4'd1) begin
      if (d.month == 4'd8 && (!lm || d.repeat8)) d.holiday = HOL_KHAO_PHANSA;
    end else if (!d.wax && d.day == 4'd8) begin
      if (d.month == (lm ? 4'd7 : 4'd6)) d.holiday = HOL_ATTAMI;
    end
    return d;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    n_fail++;
  endtask

  task automatic check_field(input string what, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  initial begin
    n_fail = 0;
    n_pending = 0;
    n_checked = 0;
    n_dated = 0;
    n_holidays = 0;
  end

  always @(posedge clk) begin
    lunar_date_t want;
    if (rst) begin
      for (int i = 0; i < NUM_YEARS; i++) year_start_q[i] <= START_RESET[i];
      flags_q <= FLAGS_RESET;
      expected_dates.delete();
      n_pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FLAGS) flags_q <= cfg_data[FLAGS_W-1:0];
        else year_start_q[cfg_index] <= cfg_data;
      end
      if (start && !busy) expected_dates.push_back(convert_time(epoch_seconds));
      if (done) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("result with no transaction outstanding", 1, 0);
        end else begin
          want = expected_dates.pop_front();
          n_checked++;
          if (want.ok) n_dated++;
          if (want.holiday != HOL_NONE) n_holidays++;
          check_field("valid_res", valid_res, want.ok);
          check_field("year_ce", year_ce, want.year);
          check_field("lunar_month", lunar_month, want.month);
          check_field("second_eighth", second_eighth, want.repeat8);
          check_field("has_leap_month", has_leap_month, want.leap);
          check_field("waxing", waxing, want.wax);
          check_field("lunar_day", lunar_day, want.day);
          check_field("zodiac_index", zodiac_index, want.zodiac);
          check_field("holy_day", holy_day, want.holy);
          check_field("holiday_code", holiday_code, want.holiday);
        end
      end
      n_pending <= expected_dates.size();
    end
  end

endmodule

// File: sim/tb_lunar_date_converter.sv
// Testbench top for the lunar date converter: clock, reset, year-table setup and time stimulus.
`timescale 1ns / 100ps

module tb_lunar_date_converter;
  import ldc_pkg::*;

  localparam int ITEMS_PER_PHASE = 340;
  localparam logic [CFG_IDX_W-1:0] REG_YEAR0 = '0;
  localparam int DAY = 86400;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [31:0]           epoch_seconds;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  done;
  logic                  valid_res;
  logic [11:0]           year_ce;
  logic [3:0]            lunar_month;
  logic                  second_eighth;
  logic                  has_leap_month;
  logic                  waxing;
  logic [3:0]            lunar_day;
  logic [3:0]            zodiac_index;
  logic                  holy_day;
  logic [2:0]            holiday_code;

  int n_fail;
  int n_pending;
  int n_checked;
  int n_dated;
  int n_holidays;
  int n_sent;
  int n_settings;
  int idle_pct;

  // stimulus-side copy of the year table, used only to aim times at real dates
  logic [31:0] tbl [NUM_YEARS];

  lunar_date_converter u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .epoch_seconds(epoch_seconds),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .valid_res(valid_res), .year_ce(year_ce), .lunar_month(lunar_month),
    .second_eighth(second_eighth), .has_leap_month(has_leap_month), .waxing(waxing),
    .lunar_day(lunar_day), .zodiac_index(zodiac_index), .holy_day(holy_day),
    .holiday_code(holiday_code)
  );

  ldc_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .epoch_seconds(epoch_seconds),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .valid_res(valid_res), .year_ce(year_ce), .lunar_month(lunar_month),
    .second_eighth(second_eighth), .has_leap_month(has_leap_month), .waxing(waxing),
    .lunar_day(lunar_day), .zodiac_index(zodiac_index), .holy_day(holy_day),
    .holiday_code(holiday_code), .n_fail(n_fail), .n_pending(n_pending),
    .n_checked(n_checked), .n_dated(n_dated), .n_holidays(n_holidays)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #(5_000_000);
    $display("timeout: %0d transaction(s) still outstanding", n_pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // hold start until the converter takes the transaction
  task automatic send_time(input logic [31:0] t);
    start <= 1'b1;
    epoch_seconds <= t;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  task automatic send_day(input int y, input int unsigned d);
    send_time(tbl[y] + d * DAY + $urandom_range(0, DAY - 1));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (n_pending != 0 || busy);
  endtask

  task automatic load_table(input logic [FLAGS_W-1:0] flags);
    drain();
    repeat (4) @(posedge clk);
    for (int i = 0; i < NUM_YEARS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_YEAR0 + CFG_IDX_W'(i);
      cfg_data <= tbl[i];
      @(posedge clk);
    end
    cfg_we <= 1'b1;
    cfg_index <= REG_FLAGS;
    cfg_data <= CFG_DATA_W'(flags);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic make_sorted(input int lo_days, input int hi_days);
    logic [31:0] base;
    base = $urandom_range(0, 32'hF000_0000);
    for (int i = 0; i < NUM_YEARS; i++) begin
      tbl[i] = base;
      base = base + $urandom_range(lo_days, hi_days) * DAY + $urandom_range(0, DAY - 1);
    end
  endtask

  function automatic logic [31:0] pick_time();
    int r;
    int y;
    int unsigned d;
    r = $urandom_range(0, 99);
    y = $urandom_range(0, NUM_YEARS - 1);
    if (r < 80) begin
      case ($urandom_range(0, 6))
        0: d = $urandom_range(0, 2);
        1: d = $urandom_range(350, 389);
        default: d = $urandom_range(0, 389);
      endcase
      return tbl[y] + d * DAY + $urandom_range(0, DAY - 1);
    end
    if (r < 90) return $urandom;
    if (r < 93) return 32'd0;
    if (r < 96) return 32'hFFFF_FFFF;
    return tbl[y] - $urandom_range(1, 3);
  endfunction

  task automatic random_phase(input bit hold_off);
    int gap;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      send_time(pick_time());
      if (hold_off && n == ITEMS_PER_PHASE / 2) begin
        drain();
      end else if ($urandom_range(0, 99) < idle_pct) begin
        gap = $urandom_range(1, 30);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    int a;
    int b;
    logic [31:0] tmp;
    rst = 1'b1;
    start = 1'b0;
    epoch_seconds = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_sent = 0;
    n_settings = 1;
    idle_pct = 29;
    for (int i = 0; i < NUM_YEARS; i++) tbl[i] = START_RESET[i];
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default table: zero, top of range, edges of the first year, holidays,
    // the end of a plain year and the end of a leap-month year
    send_time(32'd0);
    send_time(32'hFFFF_FFFF);
    send_time(tbl[0] - 1);
    send_time(tbl[0]);
    send_day(0, 43);   // Visakha
    send_day(0, 51);   // Attami
    send_day(0, 102);  // Asalha
    send_day(0, 103);  // Khao Phansa
    send_day(0, 191);  // Ok Phansa
    send_day(0, 309);  // Magha
    send_day(0, 353);
    send_day(0, 354);  // gap between a short year and the next start
    send_day(1, 118);  // first day of the repeated month 8
    send_day(1, 132);
    send_day(1, 133);
    send_day(1, 383);
    send_day(6, 384);  // past the end of the last year
    random_phase(1'b0);

    // every year leap month and leap day; month 7 grows to 30 days
    load_table(14'h3FFF);
    send_day(0, 87);
    send_day(0, 88);
    random_phase(1'b1);

    // extreme starts, no leap years, no idling on the request side
    make_sorted(354, 390);
    tbl[0] = 32'd0;
    tbl[NUM_YEARS - 1] = 32'hFFFF_FFFF;
    load_table('0);
    idle_pct = 0;
    send_time(32'd1);
    send_time(32'hFFFF_FFFF);
    random_phase(1'b0);
    idle_pct = 29;

    // unsorted starts: the highest matching index has to win
    make_sorted(200, 400);
    for (int k = 0; k < 6; k++) begin
      a = $urandom_range(0, NUM_YEARS - 1);
      b = $urandom_range(0, NUM_YEARS - 1);
      tmp = tbl[a];
      tbl[a] = tbl[b];
      tbl[b] = tmp;
    end
    load_table(FLAGS_W'($urandom));
    random_phase(1'b0);

    // tightly packed years, random flags
    make_sorted(100, 400);
    load_table(FLAGS_W'($urandom));
    random_phase(1'b0);

    drain();
    repeat (30) @(posedge clk);
    $display("Converted %0d times over %0d year tables: %0d results checked,", n_sent,
             n_settings, n_checked);
    $display("%0d fell on a lunar date and %0d on a major holiday.", n_dated, n_holidays);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ldc_pkg.sv
rtl/ldc_cfg.sv
rtl/ldc_ctrl.sv
rtl/ldc_dp.sv
rtl/lunar_date_converter.sv
sim/ldc_checker.sv
sim/tb_lunar_date_converter.sv
